### design/ssd_pkg.sv
// ---------------------------------------------------------------------------
// Seven-segment scan display package
// Shared sizes, transfer payload types and the character-to-glyph map.
// ---------------------------------------------------------------------------
package ssd_pkg;

	// Display geometry.
	localparam int DIGITS   = 7;
	localparam int SEGMENTS = 7;
	localparam int DRIVE_W  = 7;
	localparam int SEG_W    = $clog2(SEGMENTS);
	localparam int CNT_W    = $clog2(DIGITS + 1);

	// Input command codes.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef logic [SEGMENTS-1:0] glyph_t;

	// One input item.
	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [DRIVE_W-1:0] segment_drive;
		logic [DRIVE_W-1:0] digit_drive;
		logic               message_committed;
	} out_item_t;

	// Glyph bits: bit 6 is segment A, bit 0 is segment G.
	localparam glyph_t GLYPH_ROM [0:36] = '{
		7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h1F, 7'h70, 7'h7F, 7'h73,
		7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h7B, 7'h37, 7'h06, 7'h38,
		7'h7E, 7'h0E, 7'h37, 7'h15, 7'h7E, 7'h67, 7'h7E, 7'h05, 7'h5B, 7'h70,
		7'h3E, 7'h3E, 7'h7E, 7'h67, 7'h37, 7'h30,
		7'h00
	};

	localparam int BLANK_IDX = 36;

	// Digits, then letters of either case, everything else blank.
	function automatic glyph_t glyph_of(input logic [7:0] c);
		logic [7:0] idx;
		idx = 8'(BLANK_IDX);
		if (c >= 8'd48 && c <= 8'd57) begin
			idx = c - 8'd48;
		end else if (c >= 8'd97 && c <= 8'd122) begin
			idx = c - 8'd87;
		end else if (c >= 8'd65 && c <= 8'd90) begin
			idx = c - 8'd55;
		end
		return GLYPH_ROM[idx[5:0]];
	endfunction

	// Glyph shown after reset: the character '8'.
	localparam glyph_t RESET_GLYPH = 7'h7F;

endpackage

### design/ssd_item_if.sv
// ---------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one command and received byte per transfer.
// ---------------------------------------------------------------------------
interface ssd_item_if;
	import ssd_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/ssd_result_if.sv
// ---------------------------------------------------------------------------
// Result item channel
// Valid/ready channel carrying the segment and digit drive of one item.
// ---------------------------------------------------------------------------
interface ssd_result_if;
	import ssd_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/ssd_core.sv
// ---------------------------------------------------------------------------
// Seven-segment scan display core
// Holds the message buffers and scan position, and forms one result per step.
// ---------------------------------------------------------------------------
module ssd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  ssd_pkg::in_item_t item,
	output ssd_pkg::out_item_t result
);
	import ssd_pkg::*;

	// Text is held as glyphs, converted when each byte arrives.
	glyph_t           shown_q    [DIGITS];
	glyph_t           incoming_q [DIGITS];
	logic [CNT_W-1:0] count_q;
	logic [SEG_W-1:0] seg_q;

	logic [SEG_W-1:0] seg_cur;
	logic [SEG_W-1:0] seg_next;
	glyph_t           new_glyph;
	glyph_t           filled     [DIGITS];
	logic [CNT_W:0]   count_inc;
	logic             commit;

	// Out-of-range scan position falls back to segment A.
	assign seg_cur  = (seg_q >= SEG_W'(SEGMENTS)) ? '0 : seg_q;
	assign seg_next = (seg_cur == SEG_W'(SEGMENTS - 1)) ? '0 : seg_cur + SEG_W'(1);

	// Incoming buffer with the received byte placed at the fill position.
	assign new_glyph = glyph_of(item.rx_byte);
	assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			filled[i] = (count_q == CNT_W'(i)) ? new_glyph : incoming_q[i];
		end
	end

	// A zero byte or a full buffer commits the message.
	assign commit = (item.command == CMD_BYTE) &&
		((item.rx_byte == 8'd0) || (count_inc >= (CNT_W+1)'(DIGITS)));

	// Result of the current item.
	always_comb begin
		result = '0;
		if (item.command == CMD_TICK) begin
			result.segment_drive = DRIVE_W'(1) << seg_cur;
			for (int i = 0; i < DRIVE_W; i++) begin
				if (i < DIGITS) begin
					result.digit_drive[i] = !shown_q[i][SEGMENTS - 1 - int'(seg_cur)];
				end
			end
		end else begin
			result.digit_drive       = '1;
			result.message_committed = commit;
		end
	end

	// State update on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				shown_q[i]    <= RESET_GLYPH;
				incoming_q[i] <= '0;
			end
			count_q <= '0;
			seg_q   <= '0;
		end else if (step) begin
			if (item.command == CMD_TICK) begin
				seg_q <= seg_next;
			end else if (commit) begin
				for (int i = 0; i < DIGITS; i++) begin
					shown_q[i]    <= (item.rx_byte == 8'd0) ? incoming_q[i] : filled[i];
					incoming_q[i] <= '0;
				end
				count_q <= '0;
			end else begin
				for (int i = 0; i < DIGITS; i++) begin
					incoming_q[i] <= filled[i];
				end
				count_q <= count_inc[CNT_W-1:0];
			end
		end
	end
endmodule

### design/seven_segment_scan_display_unit.sv
// ---------------------------------------------------------------------------
// Seven-segment scan display unit
// Collects serial bytes into a message and scans the shown text one segment
// per tick, driving one-hot segment lines and active-low digit lines.
//
//   Channel  Direction  Payload
//   item     in         command, rx_byte
//   result   out        segment_drive, digit_drive, message_committed
//
// Each item passes through the input register and then the result
// register; one item is accepted per cycle while the result channel does not
// stall, with the single lookup and buffer update between those two registers.
// Reset shows '8' on every digit, empties the incoming message and starts
// the scan at segment A. A stalled result holds its register and the input
// register, and the item channel stops accepting only when both are full.
// ---------------------------------------------------------------------------
module seven_segment_scan_display_unit (
	input  logic         clk,
	input  logic         arst_n,
	ssd_item_if.sink     item,
	ssd_result_if.source result
);
	import ssd_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_q;
	logic      result_valid_q;
	out_item_t result_next;
	logic      advance;

	// The input stage moves on whenever the result register is free.
	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	ssd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result_next)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign result.valid = result_valid_q;
	assign result.data  = result_q;
endmodule
